// ===== rtl/framed_packet_ring_buffer_unit_defines.svh =====
// Assertion macros for the framed packet ring buffer unit.
// Used by the port checker; needs clk and rst_n in the scope that expands them.
`ifndef FRAMED_PACKET_RING_BUFFER_UNIT_DEFINES_SVH
`define FRAMED_PACKET_RING_BUFFER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FPRB_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FPRB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/fprb_pkg.sv =====
// Package for the framed packet ring buffer: request and result types, status codes,
// register indexes, reset values and controller types. No dependencies.
package fprb_pkg;

    // One request: push or pop.
    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        last_of_packet;
        logic [2:0]  status;
        logic [31:0] packets_written;
        logic [31:0] packets_read;
    } out_item_t;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_MAGIC = 3'd1;
    localparam logic [2:0] ST_BAD_LEN   = 3'd2;
    localparam logic [2:0] ST_DROPPED   = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    // Configuration register indexes.
    localparam int          CFG_INDEX_W   = 2;
    localparam logic [1:0]  CFG_MAGIC     = 2'd0;
    localparam logic [1:0]  CFG_MIN_LEN   = 2'd1;
    localparam logic [1:0]  CFG_MAX_LEN   = 2'd2;
    localparam logic [1:0]  CFG_FREE_THR  = 2'd3;

    // Register reset values.
    localparam logic [15:0] MAGIC_RESET    = 16'h3776;
    localparam logic [15:0] MIN_LEN_RESET  = 16'd60;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd9014;
    localparam logic [15:0] FREE_THR_RESET = 16'd18028;

    // Header handling.
    localparam logic [2:0]  HDR_FULL       = 3'd3;
    localparam logic [2:0]  PHASE_LEN_HI   = 3'd2;
    localparam logic [2:0]  PHASE_LEN_LO   = 3'd3;
    localparam logic [2:0]  PHASE_PAYLOAD  = 3'd4;
    localparam logic [16:0] HDR_SLACK      = 17'd7;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_PUSH,
        S_HDR,
        S_POP
    } fsm_state_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic capture;
        logic rd_issue;
        logic push_eval;
        logic pop_eval;
        logic hdr_write;
    } dp_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic hdr_accept;
        logic hdr_last;
    } dp_stat_t;

endpackage

// ===== rtl/fprb_ctrl.sv =====
// Controller state machine of the framed packet ring buffer.
// Depends on fprb_pkg for the state type and the command and status structs.
module fprb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              start_op,
    input  fprb_pkg::dp_stat_t stat,
    output fprb_pkg::dp_cmd_t  cmd,
    output logic              busy
);
    import fprb_pkg::*;

    fsm_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = (start_op == OP_POP) ? S_POP : S_PUSH;
                end
            end
            S_PUSH:
            begin
                state_next = stat.hdr_accept ? S_HDR : S_IDLE;
            end
            S_HDR:
            begin
                if (stat.hdr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        busy     = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy         = 1'b0;
                cmd.capture  = start;
                cmd.rd_issue = start && (start_op == OP_POP);
            end
            S_PUSH:
            begin
                cmd.push_eval = 1'b1;
            end
            S_HDR:
            begin
                cmd.hdr_write = 1'b1;
            end
            S_POP:
            begin
                cmd.pop_eval = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/fprb_dpath.sv =====
// Datapath of the framed packet ring buffer: ring memory, pointers, header hunting,
// pop sequencing, counters and configuration registers. Depends on fprb_pkg.
module fprb_dpath #(
    parameter int RING_BYTES = 32768
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fprb_pkg::dp_cmd_t                   cmd,
    output fprb_pkg::dp_stat_t                  stat,
    input  fprb_pkg::in_item_t                  item,
    output fprb_pkg::out_item_t                 result,
    output logic                                done,
    input  logic                                cfg_we,
    input  logic [fprb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [15:0]                         cfg_data
);
    import fprb_pkg::*;

    localparam int PW = $clog2(RING_BYTES);
    localparam int CW = (PW + 1 > 17) ? PW + 1 : 17;
    localparam logic [PW:0] RING_LEN = (PW + 1)'(RING_BYTES);

    // Pointer add with wrap; the sum always stays below twice the ring size.
    function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] p, input logic [2:0] n);
        logic [PW:0] s;
        s = {1'b0, p} + {{(PW - 2){1'b0}}, n};
        if (s >= RING_LEN)
        begin
            s = s - RING_LEN;
        end
        return s[PW-1:0];
    endfunction

    // Round a pointer up to a multiple of four, with wrap.
    function automatic logic [PW-1:0] align4(input logic [PW-1:0] p);
        logic [PW:0] s;
        s = {1'b0, p} + (PW + 1)'(3);
        s[1:0] = 2'b00;
        if (s >= RING_LEN)
        begin
            s = s - RING_LEN;
        end
        return s[PW-1:0];
    endfunction

    // Configuration registers.
    logic [15:0] magic_reg, min_len_reg, max_len_reg, free_thr_reg;

    // Write side state.
    logic [PW-1:0] cp_reg, cp_next;
    logic [PW-1:0] wc_reg, wc_next;
    logic [2:0]    hcnt_reg, hcnt_next;
    logic [31:0]   shift_reg, shift_next;
    logic [15:0]   rem_reg, rem_next;
    logic          drop_reg, drop_next;
    logic [PW-1:0] hdr_base_reg, hdr_base_next;
    logic [1:0]    hdr_idx_reg, hdr_idx_next;
    logic [31:0]   wcount_reg, wcount_next;

    // Read side state.
    logic [PW-1:0] rp_reg, rp_next;
    logic [2:0]    phase_reg, phase_next;
    logic [15:0]   rlen_reg, rlen_next;
    logic [31:0]   rcount_reg, rcount_next;

    // Captured request and result registers.
    in_item_t      item_reg;
    logic [7:0]    res_byte_reg, res_byte_next;
    logic          res_valid_reg, res_valid_next;
    logic          res_last_reg, res_last_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic          done_reg, done_next;

    // Memory ports.
    logic [7:0]    ring_mem [RING_BYTES];
    logic          mem_we;
    logic [PW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [7:0]    rd_data_reg;

    // Helper values.
    logic [31:0]   hdr_word;
    logic [15:0]   hdr_len;
    logic [PW-1:0] wc_inc, cp4, hdr_addr, rp_inc;
    logic [PW:0]   free_bytes;
    logic          no_space;
    logic [7:0]    hdr_byte;
    logic [15:0]   rlen_dec;
    logic          pop_last;

    assign hdr_word   = {shift_reg[23:0], item_reg.data_byte};
    assign hdr_len    = hdr_word[15:0];
    assign wc_inc     = wrap_add(wc_reg, 3'd1);
    assign cp4        = wrap_add(cp_reg, 3'd4);
    assign hdr_addr   = wrap_add(hdr_base_reg, {1'b0, hdr_idx_reg});
    assign rp_inc     = wrap_add(rp_reg, 3'd1);
    assign free_bytes = (rp_reg > cp_reg) ? ({1'b0, rp_reg} - {1'b0, cp_reg})
                                          : (RING_LEN - ({1'b0, cp_reg} - {1'b0, rp_reg}));
    assign no_space   = (CW'(free_bytes) < CW'(free_thr_reg))
                     || (CW'(free_bytes) <= CW'({1'b0, hdr_len} + HDR_SLACK));
    assign rlen_dec   = (rlen_reg != 16'd0) ? (rlen_reg - 16'd1) : rlen_reg;

    // Header bytes go out most significant first.
    always_comb
    begin
        unique case (hdr_idx_reg)
            2'd0:    hdr_byte = shift_reg[31:24];
            2'd1:    hdr_byte = shift_reg[23:16];
            2'd2:    hdr_byte = shift_reg[15:8];
            default: hdr_byte = shift_reg[7:0];
        endcase
    end

    // Write side: payload storing, dropping, header hunting and header writes.
    always_comb
    begin
        cp_next       = cp_reg;
        wc_next       = wc_reg;
        hcnt_next     = hcnt_reg;
        shift_next    = shift_reg;
        rem_next      = rem_reg;
        drop_next     = drop_reg;
        hdr_base_next = hdr_base_reg;
        hdr_idx_next  = hdr_idx_reg;
        wcount_next   = wcount_reg;
        mem_we        = 1'b0;
        mem_waddr     = wc_reg;
        mem_wdata     = item_reg.data_byte;
        stat          = '0;
        stat.hdr_last = (hdr_idx_reg == 2'd3);
        res_status_next = res_status_reg;

        if (cmd.push_eval)
        begin
            res_status_next = ST_OK;
            hdr_idx_next    = 2'd0;
            if (rem_reg != 16'd0)
            begin
                rem_next = rem_reg - 16'd1;
                if (drop_reg)
                begin
                    if (rem_reg == 16'd1)
                    begin
                        drop_next = 1'b0;
                    end
                    res_status_next = ST_DROPPED;
                end
                else
                begin
                    mem_we = 1'b1;
                    if (rem_reg == 16'd1)
                    begin
                        cp_next     = align4(wc_inc);
                        wc_next     = align4(wc_inc);
                        wcount_next = wcount_reg + 32'd1;
                    end
                    else
                    begin
                        wc_next = wc_inc;
                    end
                end
            end
            else
            begin
                shift_next = hdr_word;
                if (hcnt_reg < HDR_FULL)
                begin
                    hcnt_next = hcnt_reg + 3'd1;
                end
                else if (hdr_word[31:16] != magic_reg)
                begin
                    hcnt_next       = HDR_FULL;
                    res_status_next = ST_BAD_MAGIC;
                end
                else if ((hdr_len < min_len_reg) || (hdr_len > max_len_reg))
                begin
                    hcnt_next       = HDR_FULL;
                    res_status_next = ST_BAD_LEN;
                end
                else if (no_space)
                begin
                    hcnt_next       = 3'd0;
                    rem_next        = hdr_len;
                    drop_next       = (hdr_len != 16'd0);
                    res_status_next = ST_DROPPED;
                end
                else
                begin
                    // Accepted header: the four bytes are written over the next cycles.
                    hcnt_next       = 3'd0;
                    stat.hdr_accept = 1'b1;
                    hdr_base_next   = cp_reg;
                    wc_next         = cp4;
                    rem_next        = hdr_len;
                    drop_next       = 1'b0;
                    if (hdr_len == 16'd0)
                    begin
                        cp_next     = align4(cp4);
                        wc_next     = align4(cp4);
                        wcount_next = wcount_reg + 32'd1;
                    end
                end
            end
        end
        else if (cmd.hdr_write)
        begin
            mem_we       = 1'b1;
            mem_waddr    = hdr_addr;
            mem_wdata    = hdr_byte;
            hdr_idx_next = hdr_idx_reg + 2'd1;
        end
        else if (cmd.pop_eval)
        begin
            res_status_next = (phase_reg == 3'd0 && rp_reg == cp_reg) ? ST_EMPTY : ST_OK;
        end
    end

    // Read side: header length capture, payload countdown and packet end.
    always_comb
    begin
        rp_next        = rp_reg;
        phase_next     = phase_reg;
        rlen_next      = rlen_reg;
        rcount_next    = rcount_reg;
        pop_last       = 1'b0;
        res_byte_next  = 8'd0;
        res_valid_next = 1'b0;
        res_last_next  = 1'b0;

        if (cmd.pop_eval && !(phase_reg == 3'd0 && rp_reg == cp_reg))
        begin
            res_byte_next  = rd_data_reg;
            res_valid_next = 1'b1;
            rp_next        = rp_inc;
            if (phase_reg < PHASE_PAYLOAD)
            begin
                if (phase_reg == PHASE_LEN_HI)
                begin
                    rlen_next = {rd_data_reg, 8'd0};
                end
                else if (phase_reg == PHASE_LEN_LO)
                begin
                    rlen_next = rlen_reg | {8'd0, rd_data_reg};
                end
                phase_next = phase_reg + 3'd1;
                pop_last   = (phase_next == PHASE_PAYLOAD) && (rlen_next == 16'd0);
            end
            else
            begin
                rlen_next = rlen_dec;
                pop_last  = (rlen_dec == 16'd0);
            end
            if (pop_last)
            begin
                rp_next     = align4(rp_inc);
                phase_next  = 3'd0;
                rcount_next = rcount_reg + 32'd1;
            end
            res_last_next = pop_last;
        end
        done_next = cmd.push_eval || cmd.pop_eval;
    end

    // Ring memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= ring_mem[rp_reg];
        end
    end

    // Request capture and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= item;
        end
        if (cmd.push_eval || cmd.pop_eval)
        begin
            res_byte_reg  <= res_byte_next;
            res_valid_reg <= res_valid_next;
            res_last_reg  <= res_last_next;
        end
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg      <= MAGIC_RESET;
            min_len_reg    <= MIN_LEN_RESET;
            max_len_reg    <= MAX_LEN_RESET;
            free_thr_reg   <= FREE_THR_RESET;
            cp_reg         <= '0;
            wc_reg         <= '0;
            hcnt_reg       <= '0;
            shift_reg      <= '0;
            rem_reg        <= '0;
            drop_reg       <= 1'b0;
            hdr_base_reg   <= '0;
            hdr_idx_reg    <= '0;
            wcount_reg     <= '0;
            rp_reg         <= '0;
            phase_reg      <= '0;
            rlen_reg       <= '0;
            rcount_reg     <= '0;
            res_status_reg <= ST_OK;
            done_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MAGIC:    magic_reg    <= cfg_data;
                    CFG_MIN_LEN:  min_len_reg  <= cfg_data;
                    CFG_MAX_LEN:  max_len_reg  <= cfg_data;
                    CFG_FREE_THR: free_thr_reg <= cfg_data;
                    default:      magic_reg    <= magic_reg;
                endcase
            end
            cp_reg         <= cp_next;
            wc_reg         <= wc_next;
            hcnt_reg       <= hcnt_next;
            shift_reg      <= shift_next;
            rem_reg        <= rem_next;
            drop_reg       <= drop_next;
            hdr_base_reg   <= hdr_base_next;
            hdr_idx_reg    <= hdr_idx_next;
            wcount_reg     <= wcount_next;
            rp_reg         <= rp_next;
            phase_reg      <= phase_next;
            rlen_reg       <= rlen_next;
            rcount_reg     <= rcount_next;
            res_status_reg <= res_status_next;
            done_reg       <= done_next;
        end
    end

    // Result outputs; the counters are shown as they stand after the request.
    assign result.out_byte        = res_byte_reg;
    assign result.out_valid       = res_valid_reg;
    assign result.last_of_packet  = res_last_reg;
    assign result.status          = res_status_reg;
    assign result.packets_written = wcount_reg;
    assign result.packets_read    = rcount_reg;
    assign done                   = done_reg;

endmodule

// ===== rtl/framed_packet_ring_buffer_unit.sv =====
// Framed packet ring buffer unit: one result per request, strobed by done for one cycle.
// The request is evaluated in the cycle after acceptance and its result is taken at the
// next edge; a pop reads the ring at the accepting edge. A new request is taken only when
// the unit is idle again; a push that completes an accepted header holds busy on while the
// header bytes are written. The receiver cannot stall the unit. Reset clears
// pointers, counters and header state and loads register defaults; ring contents are kept.
module framed_packet_ring_buffer_unit #(
    parameter int RING_BYTES = 32768
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fprb_pkg::in_item_t               item,
    output logic                             done,
    output fprb_pkg::out_item_t              result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [fprb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                      cfg_data
);
    import fprb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Register writes are always taken.
    assign cfg_ready = 1'b1;

    // Controller.
    fprb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .start_op (item.operation),
        .stat     (stat),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Datapath.
    fprb_dpath #(
        .RING_BYTES (RING_BYTES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .item      (item),
        .result    (result),
        .done      (done),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

// ===== rtl/fprb_checker.sv =====
// Port checker for the framed packet ring buffer unit, bound to the top level.
// Depends on fprb_pkg and framed_packet_ring_buffer_unit_defines.svh.
`include "framed_packet_ring_buffer_unit_defines.svh"

module fprb_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input fprb_pkg::out_item_t result
);
    import fprb_pkg::*;

    // An accepted request holds the block busy in the following cycle.
    `FPRB_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")

    // A result never shows in the cycle right after acceptance.
    `FPRB_ASSERT_NEXT(a_no_early_done, start && !busy, !done, "result strobed too early")

    // A packet end is only marked on a popped byte.
    `FPRB_ASSERT_SAME(a_last_valid, done && result.last_of_packet, result.out_valid, "last without byte")

    // A popped byte always carries an ok status.
    `FPRB_ASSERT_SAME(a_valid_ok, done && result.out_valid, result.status == ST_OK, "popped byte with error")

    // With no popped byte the byte field is zero.
    `FPRB_ASSERT_SAME(a_idle_zero, done && !result.out_valid, result.out_byte == 8'd0, "stray byte")

endmodule

bind framed_packet_ring_buffer_unit fprb_checker u_fprb_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
